/* rtl/chs_pkg.sv */
`timescale 1ns / 1ps

package chs_pkg;

   localparam int MAX_POINTS = 64;
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int IDX_W      = $clog2(MAX_POINTS);

   localparam logic [1:0] FN_CLEAR  = 2'd0;
   localparam logic [1:0] FN_APPEND = 2'd1;
   localparam logic [1:0] FN_INTERP = 2'd2;

   typedef struct packed {
      logic [1:0]         func;
      logic signed [31:0] x_value;
      logic signed [31:0] y_value;
   } chs_req_type;

   typedef struct packed {
      logic signed [31:0] y_result;
      logic               in_segment;
      logic               too_few_knots;
   } chs_rsp_type;

   // query token walking the knot chain
   typedef struct packed {
      logic               active;
      logic               found;
      logic               need_far;
      logic               has_prev;
      logic               left_ok;
      logic               has_far;
      logic signed [31:0] q;
      logic signed [31:0] prev_x;
      logic signed [31:0] prev_y;
      logic signed [31:0] lx;
      logic signed [31:0] ly;
      logic signed [31:0] xl;
      logic signed [31:0] yl;
      logic signed [31:0] xr;
      logic signed [31:0] yr;
      logic signed [31:0] fx;
      logic signed [31:0] fy;
      logic signed [31:0] last_y;
   } chs_token_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [65:0] hi;
      logic signed [65:0] lo;
      hi = 66'sh0_7FFF_FFFF;
      lo = -66'sh0_8000_0000;
      if (v > hi) begin
         return 32'sh7FFF_FFFF;
      end else if (v < lo) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

endpackage

/* rtl/chs_cell.sv */
`timescale 1ns / 1ps

module chs_cell import chs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [IDX_W-1:0]   cell_idx,
   input  logic [CNT_W-1:0]   count,
   input  logic               app_en,
   input  logic signed [31:0] app_x,
   input  logic signed [31:0] app_y,
   input  logic signed [31:0] next_x,
   input  logic signed [31:0] next_y,
   input  chs_token_type      tok_in,
   output logic signed [31:0] knot_x,
   output logic signed [31:0] knot_y,
   output chs_token_type      tok_out
);

   logic signed [31:0] x_ff;
   logic signed [31:0] y_ff;
   chs_token_type      tok_ff;
   chs_token_type      tok_in_nxt;
   logic               kv;
   logic               nv;

   assign kv = CNT_W'(cell_idx) < count;
   assign nv = (CNT_W'(cell_idx) + CNT_W'(1)) < count;

   always_comb begin
      tok_in_nxt = tok_in;
      if (tok_in.active) begin
         if (kv) begin
            tok_in_nxt.last_y = y_ff;
         end
         if (!tok_in.found && nv && (x_ff < tok_in.q) && (tok_in.q <= next_x)) begin
            tok_in_nxt.found    = 1'b1;
            tok_in_nxt.need_far = 1'b1;
            tok_in_nxt.left_ok  = tok_in.has_prev;
            tok_in_nxt.lx       = tok_in.prev_x;
            tok_in_nxt.ly       = tok_in.prev_y;
            tok_in_nxt.xl       = x_ff;
            tok_in_nxt.yl       = y_ff;
            tok_in_nxt.xr       = next_x;
            tok_in_nxt.yr       = next_y;
         end else if (tok_in.found && tok_in.need_far) begin
            tok_in_nxt.need_far = 1'b0;
            tok_in_nxt.has_far  = nv;
            tok_in_nxt.fx       = next_x;
            tok_in_nxt.fy       = next_y;
         end
         tok_in_nxt.prev_x   = x_ff;
         tok_in_nxt.prev_y   = y_ff;
         tok_in_nxt.has_prev = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (app_en && (CNT_W'(cell_idx) == count)) begin
         x_ff <= app_x;
         y_ff <= app_y;
      end
      if (reset) begin
         tok_ff.active <= 1'b0;
      end else begin
         tok_ff <= tok_in_nxt;
      end
   end

   assign knot_x  = x_ff;
   assign knot_y  = y_ff;
   assign tok_out = tok_ff;

endmodule

/* rtl/chs_div.sv */
`timescale 1ns / 1ps

module chs_div import chs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [47:0] num,
   input  logic [31:0] den,
   output logic        done,
   output logic [47:0] quo
);

   logic        busy_ff;
   logic        done_ff;
   logic [5:0]  cnt_ff;
   logic [31:0] rem_ff;
   logic [47:0] quo_ff;
   logic [31:0] den_ff;
   logic [32:0] rem_sh;
   logic        take;

   assign rem_sh = {rem_ff, quo_ff[47]};
   assign take   = rem_sh >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            quo_ff  <= num;
            den_ff  <= den;
         end else if (busy_ff) begin
            rem_ff <= take ? 32'(rem_sh - {1'b0, den_ff}) : rem_sh[31:0];
            quo_ff <= {quo_ff[46:0], take};
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd47) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

/* rtl/cubic_hermite_spline_interp.sv */
`timescale 1ns / 1ps
// Channel  Direction  Handshake          Payload
// req      in         req_valid/stall    chs_req_type (func, x_value, y_value)
// rsp      out        rsp_valid/stall    chs_rsp_type (y_result, in_segment, too_few_knots)
// csr      in         csr_valid/ready    csr_data = use_slopes
//
// Clear and append are handled in ST_IDLE. A query with two or more knots walks
// the chain of MAX_POINTS knot cells, then runs up to four divisions on the
// shared divider (only the t division without slopes) and the multiply stages
// ST_MUL_A, ST_MUL_B and ST_MUL_C, then ST_SUM. Reset is synchronous and empties
// the table. A query result waits in the output register while rsp_stall holds.

module cubic_hermite_spline_interp import chs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  chs_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output chs_rsp_type rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_WALK, ST_DIV_GO, ST_DIV_WAIT,
      ST_MUL_A, ST_MUL_B, ST_MUL_C, ST_SUM, ST_OUT
   } state_type;

   typedef enum logic [1:0] {SEL_T, SEL_S0, SEL_SL, SEL_SR} sel_type;

   state_type          state_ff;
   sel_type            sel_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               use_slopes_ff;
   chs_token_type      res_ff;
   chs_rsp_type        pend_ff;
   chs_rsp_type        rsp_data_ff;
   logic               rsp_valid_ff;
   logic [16:0]        t_ff;
   logic signed [31:0] sec0_ff;
   logic signed [31:0] secl_ff;
   logic signed [31:0] secr_ff;
   logic [32:0]        uu_ff;
   logic [32:0]        tt_ff;
   logic signed [31:0] sl_ff;
   logic signed [31:0] sr_ff;
   logic [16:0]        h00_ff;
   logic [16:0]        h01_ff;
   logic [16:0]        h10_ff;
   logic [16:0]        h11_ff;
   logic signed [48:0] wsl_ff;
   logic signed [48:0] wsr_ff;
   logic signed [49:0] p0_ff;
   logic signed [49:0] p1_ff;
   logic signed [65:0] q0_ff;
   logic signed [65:0] q1_ff;

   logic               req_acc;
   logic               app_en;
   chs_token_type      tok_head;
   chs_token_type      tok_w [MAX_POINTS+1];
   logic signed [31:0] kx_w  [MAX_POINTS];
   logic signed [31:0] ky_w  [MAX_POINTS];

   logic signed [31:0] ax, ay, bx, by;
   logic signed [32:0] dx, dy, dx_mag, dy_mag;
   logic               neg, dz;
   logic               div_start, div_done;
   logic [47:0]        div_quo;
   logic signed [48:0] qmag, qs;
   logic signed [31:0] sec_val;

   logic [16:0]        u_val;
   logic signed [32:0] w_val;
   logic signed [32:0] sl_sum, sr_sum;
   logic [49:0]        h00_prod, h01_prod, h10_prod, h11_prod;
   logic signed [64:0] wsl_prod, wsr_prod;
   logic signed [49:0] p0_prod, p1_prod;
   logic signed [66:0] q0_prod, q1_prod;
   logic signed [65:0] acc;

   assign req_stall = state_ff != ST_IDLE;
   assign req_acc   = req_valid && !req_stall;
   assign app_en    = req_acc && (req_data.func == FN_APPEND)
                      && (count_ff < CNT_W'(MAX_POINTS));
   assign csr_ready = 1'b1;

   always_comb begin
      tok_head        = '0;
      tok_head.active = req_acc && (req_data.func == FN_INTERP) && (count_ff >= CNT_W'(2));
      tok_head.q      = req_data.x_value;
   end

   assign tok_w[0] = tok_head;

   for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
      logic signed [31:0] nx, ny;
      if (g < MAX_POINTS - 1) begin : g_mid
         assign nx = kx_w[g+1];
         assign ny = ky_w[g+1];
      end else begin : g_end
         assign nx = '0;
         assign ny = '0;
      end
      chs_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (IDX_W'(g)),
         .count    (count_ff),
         .app_en   (app_en),
         .app_x    (req_data.x_value),
         .app_y    (req_data.y_value),
         .next_x   (nx),
         .next_y   (ny),
         .tok_in   (tok_w[g]),
         .knot_x   (kx_w[g]),
         .knot_y   (ky_w[g]),
         .tok_out  (tok_w[g+1])
      );
   end

   always_comb begin
      case (sel_ff)
         SEL_T: begin
            ax = res_ff.xl; ay = res_ff.xl; bx = res_ff.xr; by = res_ff.q;
         end
         SEL_SL: begin
            ax = res_ff.lx; ay = res_ff.ly; bx = res_ff.xl; by = res_ff.yl;
         end
         SEL_SR: begin
            ax = res_ff.xr; ay = res_ff.yr; bx = res_ff.fx; by = res_ff.fy;
         end
         default: begin
            ax = res_ff.xl; ay = res_ff.yl; bx = res_ff.xr; by = res_ff.yr;
         end
      endcase
   end

   assign dx        = {bx[31], bx} - {ax[31], ax};
   assign dy        = {by[31], by} - {ay[31], ay};
   assign dx_mag    = dx[32] ? -dx : dx;
   assign dy_mag    = dy[32] ? -dy : dy;
   assign neg       = dx[32] ^ dy[32];
   assign dz        = dx == 33'sd0;
   assign div_start = state_ff == ST_DIV_GO;

   chs_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   ({dy_mag[31:0], 16'd0}),
      .den   (dx_mag[31:0]),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign qmag    = {1'b0, div_quo};
   assign qs      = neg ? -qmag : qmag;
   assign sec_val = dz ? 32'sd0 : sat32({{17{qs[48]}}, qs});

   assign u_val    = 17'd65536 - t_ff;
   assign w_val    = {res_ff.xr[31], res_ff.xr} - {res_ff.xl[31], res_ff.xl};
   assign sl_sum   = {secl_ff[31], secl_ff} + {sec0_ff[31], sec0_ff};
   assign sr_sum   = {sec0_ff[31], sec0_ff} + {secr_ff[31], secr_ff};
   assign h00_prod = (50'd65536 + 50'({t_ff, 1'b0})) * 50'(uu_ff);
   assign h01_prod = 50'(tt_ff) * (50'd196608 - 50'({t_ff, 1'b0}));
   assign h10_prod = 50'(t_ff) * 50'(uu_ff);
   assign h11_prod = 50'(tt_ff) * 50'(u_val);
   assign wsl_prod = w_val * sl_ff;
   assign wsr_prod = w_val * sr_ff;
   assign p0_prod  = $signed({1'b0, h00_ff}) * res_ff.yl;
   assign p1_prod  = $signed({1'b0, h01_ff}) * res_ff.yr;
   assign q0_prod  = $signed({1'b0, h10_ff}) * wsl_ff;
   assign q1_prod  = $signed({1'b0, h11_ff}) * wsr_ff;
   assign acc      = 66'(p0_ff) + 66'(p1_ff)
                     + (use_slopes_ff ? (q0_ff - q1_ff) : 66'sd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         sel_ff        <= SEL_T;
         count_ff      <= '0;
         use_slopes_ff <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            use_slopes_ff <= csr_data;
         end
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_acc) begin
                  case (req_data.func)
                     FN_CLEAR: count_ff <= '0;
                     FN_APPEND: begin
                        if (app_en) begin
                           count_ff <= count_ff + CNT_W'(1);
                        end
                     end
                     FN_INTERP: begin
                        if (count_ff < CNT_W'(2)) begin
                           pend_ff  <= '{y_result: 32'sd0, in_segment: 1'b0,
                                         too_few_knots: 1'b1};
                           state_ff <= ST_OUT;
                        end else begin
                           state_ff <= ST_WALK;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            ST_WALK: begin
               if (tok_w[MAX_POINTS].active) begin
                  res_ff <= tok_w[MAX_POINTS];
                  if (tok_w[MAX_POINTS].found) begin
                     sel_ff   <= SEL_T;
                     state_ff <= ST_DIV_GO;
                  end else begin
                     pend_ff  <= '{y_result: tok_w[MAX_POINTS].last_y, in_segment: 1'b0,
                                   too_few_knots: 1'b0};
                     state_ff <= ST_OUT;
                  end
               end
            end
            ST_DIV_GO: state_ff <= ST_DIV_WAIT;
            ST_DIV_WAIT: begin
               if (div_done) begin
                  case (sel_ff)
                     SEL_T: begin
                        t_ff <= div_quo[16:0];
                        if (use_slopes_ff) begin
                           sel_ff   <= SEL_S0;
                           state_ff <= ST_DIV_GO;
                        end else begin
                           state_ff <= ST_MUL_A;
                        end
                     end
                     SEL_S0: begin
                        sec0_ff <= sec_val;
                        if (res_ff.left_ok) begin
                           sel_ff   <= SEL_SL;
                           state_ff <= ST_DIV_GO;
                        end else if (res_ff.has_far) begin
                           sel_ff   <= SEL_SR;
                           state_ff <= ST_DIV_GO;
                        end else begin
                           state_ff <= ST_MUL_A;
                        end
                     end
                     SEL_SL: begin
                        secl_ff <= sec_val;
                        if (res_ff.has_far) begin
                           sel_ff   <= SEL_SR;
                           state_ff <= ST_DIV_GO;
                        end else begin
                           state_ff <= ST_MUL_A;
                        end
                     end
                     default: begin
                        secr_ff  <= sec_val;
                        state_ff <= ST_MUL_A;
                     end
                  endcase
               end
            end
            ST_MUL_A: begin
               uu_ff    <= 33'(34'(u_val) * 34'(u_val));
               tt_ff    <= 33'(34'(t_ff) * 34'(t_ff));
               sl_ff    <= res_ff.left_ok ? 32'(sl_sum >>> 1) : sec0_ff;
               sr_ff    <= res_ff.has_far ? 32'(sr_sum >>> 1) : sec0_ff;
               state_ff <= ST_MUL_B;
            end
            ST_MUL_B: begin
               h00_ff   <= h00_prod[48:32];
               h01_ff   <= h01_prod[48:32];
               h10_ff   <= h10_prod[48:32];
               h11_ff   <= h11_prod[48:32];
               wsl_ff   <= wsl_prod[64:16];
               wsr_ff   <= wsr_prod[64:16];
               state_ff <= ST_MUL_C;
            end
            ST_MUL_C: begin
               p0_ff    <= p0_prod;
               p1_ff    <= p1_prod;
               q0_ff    <= q0_prod[65:0];
               q1_ff    <= q1_prod[65:0];
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               pend_ff  <= '{y_result: sat32(acc >>> 16), in_segment: 1'b1,
                             too_few_knots: 1'b0};
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= pend_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

class spline_scoreboard;
   logic signed [31:0] kx[64];
   logic signed [31:0] ky[64];
   int unsigned        count;
   bit                 slopes;
   chs_pkg::chs_rsp_type pending[$];
   int                 errors;

   function new();
      count  = 0;
      slopes = 1'b1;
      errors = 0;
   endfunction

   function longint fshift(longint v, int s);
      if (v >= 0) return v >>> s;
      return -((-(v + 1)) >>> s) - 1;
   endfunction

   function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function longint secant(int j);
      longint dx, dy;
      dx = longint'(kx[j + 1]) - longint'(kx[j]);
      dy = longint'(ky[j + 1]) - longint'(ky[j]);
      if (dx == 0) return 0;
      return clamp32((dy * 65536) / dx);
   endfunction

   function longint slope_at(int i, int n);
      if (i == 0) return secant(0);
      if (i >= n - 1) return secant(n - 2);
      return fshift(secant(i - 1) + secant(i), 1);
   endfunction

   function void note_request(chs_pkg::chs_req_type r);
      chs_pkg::chs_rsp_type e;
      longint w, d, tt, uu, h00, h01, h10, h11, acc;
      int n;
      bit hit;
      n = count;
      hit = 1'b0;
      case (r.func)
         chs_pkg::FN_CLEAR: begin
            count = 0;
         end
         chs_pkg::FN_APPEND: begin
            if (count < 64) begin
               kx[count] = r.x_value;
               ky[count] = r.y_value;
               count++;
            end
         end
         chs_pkg::FN_INTERP: begin
            e = '0;
            if (n < 2) begin
               e.too_few_knots = 1'b1;
            end else begin
               for (int i = 0; i + 1 < n && !hit; i++) begin
                  if (kx[i] < r.x_value && r.x_value <= kx[i + 1]) begin
                     hit = 1'b1;
                     w = longint'(kx[i + 1]) - longint'(kx[i]);
                     d = longint'(r.x_value) - longint'(kx[i]);
                     tt = (d * 65536) / w;
                     uu = 65536 - tt;
                     h00 = ((65536 + 2 * tt) * uu * uu) >>> 32;
                     h01 = (tt * tt * (196608 - 2 * tt)) >>> 32;
                     acc = h00 * longint'(ky[i]) + h01 * longint'(ky[i + 1]);
                     if (slopes) begin
                        h10 = (tt * uu * uu) >>> 32;
                        h11 = (tt * tt * uu) >>> 32;
                        acc += h10 * fshift(w * slope_at(i, n), 16)
                               - h11 * fshift(w * slope_at(i + 1, n), 16);
                     end
                     e.y_result   = 32'(clamp32(fshift(acc, 16)));
                     e.in_segment = 1'b1;
                  end
               end
               if (!hit) e.y_result = ky[n - 1];
            end
            pending.insert(pending.size(), e);
         end
         default: ;
      endcase
   endfunction

   function void check_result(chs_pkg::chs_rsp_type a);
      chs_pkg::chs_rsp_type e;
      if (pending.size() == 0) begin
         $display("%0t: unexpected result, expected none, actual %h", $time, a);
         errors++;
         return;
      end
      e = pending.pop_front();
      if (a.y_result !== e.y_result)
         $display("%0t: y_result expected %h actual %h", $time, e.y_result, a.y_result);
      if (a.in_segment !== e.in_segment)
         $display("%0t: in_segment expected %b actual %b", $time, e.in_segment,
                  a.in_segment);
      if (a.too_few_knots !== e.too_few_knots)
         $display("%0t: too_few_knots expected %b actual %b", $time, e.too_few_knots,
                  a.too_few_knots);
      if (a !== e) errors++;
   endfunction
endclass

module tb_top;
   import chs_pkg::*;

   localparam logic [1:0] FN_UNKNOWN = 2'd3;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   chs_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   chs_rsp_type rsp_data;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic        csr_data = 0;

   spline_scoreboard sb = new();
   bit calm = 0;
   bit hold_off = 0;

   cubic_hermite_spline_interp dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
      if (hold_off) rsp_stall <= 1'b1;
      else rsp_stall <= !calm && ($urandom_range(99) < 15);
   end

   // valid stays up after the transaction is taken; drain drops it
   task automatic send(logic [1:0] f, logic signed [31:0] xv, logic signed [31:0] yv);
      while (!calm && $urandom_range(99) < 15) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{func: f, x_value: xv, y_value: yv};
      do @(posedge clock); while (req_stall);
      sb.note_request(req_data);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_slopes(logic v);
      csr_valid <= 1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      sb.slopes = v;
      csr_valid <= 0;
   endtask

   function automatic logic signed [31:0] rnd_word();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $signed($urandom_range(2000)) - 1000;
         2: return $signed($urandom) >>> 8;
         default: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      endcase
   endfunction

   task automatic load_table(int n);
      logic signed [31:0] xv;
      int step;
      send(FN_CLEAR, rnd_word(), rnd_word());
      step = $urandom_range(3) == 0 ? 32'h0400_0000 : $urandom_range(1 << 20, 1);
      xv = -$signed(step) * $signed($urandom_range(n));
      for (int i = 0; i < n; i++) begin
         send(FN_APPEND, $urandom_range(15) == 0 ? rnd_word() : xv, rnd_word());
         xv = xv + $signed($urandom_range(step, 0));
      end
   endtask

   initial begin
      logic signed [31:0] lo, hi;
      int items;
      int next_cfg;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed
      send(FN_INTERP, 0, 0);
      send(FN_APPEND, 32'sh0001_0000, 32'sh7FFF_FFFF);
      send(FN_INTERP, 32'sh0001_0000, 0);
      send(FN_APPEND, 32'sh0003_0000, 32'sh8000_0000);
      send(FN_APPEND, 32'sh0003_0000, 32'sh0001_0000);
      send(FN_APPEND, 32'sh0002_0000, 32'sh0005_0000);
      send(FN_APPEND, 32'sh7FFF_FFFF, 32'sh8000_0000);
      send(FN_INTERP, 32'sh0002_0000, 0);
      send(FN_INTERP, 32'sh0003_0000, 0);
      send(FN_INTERP, 32'sh0001_0000, 0);
      send(FN_INTERP, 32'sh8000_0000, 0);
      send(FN_INTERP, 32'sh7FFF_FFFF, 0);
      send(FN_UNKNOWN, 32'sh1234_5678, -1);
      send(FN_CLEAR, 0, 0);
      send(FN_APPEND, 32'sh8000_0000, 32'sh7FFF_FFFF);
      send(FN_APPEND, 32'sh7FFF_FFFF, 32'sh8000_0000);
      send(FN_INTERP, 32'sh0000_0000, -1);
      send(FN_INTERP, 32'sh7FFF_FFFF, -1);
      drain();
      write_slopes(0);
      send(FN_INTERP, 32'sh0000_0000, 0);
      send(FN_INTERP, 32'sh7FFF_FFFF, 0);
      drain();
      write_slopes(1);
      for (int i = 0; i < 66; i++) send(FN_APPEND, 32'sh7FFF_FFFF, i);
      send(FN_INTERP, 32'sh7FFF_FFFF, 0);
      // receiver holds off while the sender keeps going
      hold_off = 1;
      fork
         begin
            repeat (3000) @(posedge clock);
            hold_off = 0;
         end
         begin
            for (int i = 0; i < 6; i++) send(FN_INTERP, rnd_word(), 0);
            req_valid <= 1'b0;
         end
      join
      drain();
      items = 0;
      next_cfg = 0;
      while (items < 1900) begin
         if (items >= next_cfg) begin
            drain();
            write_slopes(1'($urandom_range(1)));
            next_cfg += 300;
         end
         calm = (items >= 600 && items < 800);
         load_table($urandom_range(9) == 0 ? 64 : $urandom_range(8, 1));
         items += sb.count + 1;
         lo = sb.kx[0];
         hi = sb.kx[sb.count - 1];
         for (int q = 0; q < 8; q++) begin
            if ($urandom_range(4) == 0) send(FN_INTERP, rnd_word(), rnd_word());
            else if (hi > lo)
               send(FN_INTERP, lo + $signed($urandom_range(hi - lo)), rnd_word());
            else send(FN_INTERP, lo, rnd_word());
            items++;
         end
         if ($urandom_range(9) == 0) send(FN_UNKNOWN, rnd_word(), rnd_word());
      end
      calm = 0;
      drain();
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #60ms;
      $display("Simulation FAILED");
      $finish;
   end
endmodule

/* files.f */
rtl/chs_pkg.sv
rtl/chs_cell.sv
rtl/chs_div.sv
rtl/cubic_hermite_spline_interp.sv
tb/tb_top.sv
